[sv/sgfw_pkg.sv]
// Shared types, constants and functions of the scaled glyph framebuffer writer.
// Holds the font table and the queue entry format; depends on nothing.
package sgfw_pkg;

  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 4;

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h5A;
  localparam int GLYPH_COLS  = 5;
  // Two destination columns and two pages for every glyph column.
  localparam int DRAW_STEPS  = 4 * GLYPH_COLS;
  localparam int STEP_W      = $clog2(DRAW_STEPS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DRAW,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] x;
    logic [1:0] page;
    logic [5:0] glyph;
    logic       in_range;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

  typedef struct packed {
    logic init_busy;
  } eng_stat_t;

  function automatic logic [7:0] double_nibble(input logic [3:0] n);
    logic [7:0] r;
    for (int i = 0; i < 4; i++) begin
      r[2*i]   = n[i];
      r[2*i+1] = n[i];
    end
    return r;
  endfunction

  // Column c (0 is leftmost) of the glyph at table index idx.
  function automatic logic [7:0] glyph_col(input logic [5:0] idx, input logic [2:0] c);
    logic [39:0] g;
    logic [7:0]  b;
    case (idx)
      6'd0:  g = 40'h00_00_00_00_00;
      6'd1:  g = 40'h00_00_5F_00_00;
      6'd2:  g = 40'h00_07_00_07_00;
      6'd3:  g = 40'h14_7F_14_7F_14;
      6'd4:  g = 40'h24_2A_7F_2A_12;
      6'd5:  g = 40'h23_13_08_64_62;
      6'd6:  g = 40'h36_49_55_22_50;
      6'd7:  g = 40'h00_05_03_00_00;
      6'd8:  g = 40'h00_1C_22_41_00;
      6'd9:  g = 40'h00_41_22_1C_00;
      6'd10: g = 40'h08_2A_1C_2A_08;
      6'd11: g = 40'h08_08_3E_08_08;
      6'd12: g = 40'h00_50_30_00_00;
      6'd13: g = 40'h08_08_08_08_08;
      6'd14: g = 40'h00_60_60_00_00;
      6'd15: g = 40'h20_10_08_04_02;
      6'd16: g = 40'h3E_51_49_45_3E;
      6'd17: g = 40'h00_42_7F_40_00;
      6'd18: g = 40'h42_61_51_49_46;
      6'd19: g = 40'h21_41_45_4B_31;
      6'd20: g = 40'h18_14_12_7F_10;
      6'd21: g = 40'h27_45_45_45_39;
      6'd22: g = 40'h3C_4A_49_49_30;
      6'd23: g = 40'h01_71_09_05_03;
      6'd24: g = 40'h36_49_49_49_36;
      6'd25: g = 40'h06_49_49_29_1E;
      6'd26: g = 40'h00_36_36_00_00;
      6'd27: g = 40'h00_56_36_00_00;
      6'd28: g = 40'h08_14_22_41_00;
      6'd29: g = 40'h14_14_14_14_14;
      6'd30: g = 40'h41_22_14_08_00;
      6'd31: g = 40'h02_01_51_09_06;
      6'd32: g = 40'h32_49_79_41_3E;
      6'd33: g = 40'h7E_09_09_09_7E;
      6'd34: g = 40'h7F_49_49_49_36;
      6'd35: g = 40'h3E_41_41_41_22;
      6'd36: g = 40'h7F_41_41_22_1C;
      6'd37: g = 40'h7F_49_49_49_41;
      6'd38: g = 40'h7F_09_09_09_01;
      6'd39: g = 40'h3E_41_49_49_7A;
      6'd40: g = 40'h7F_08_08_08_7F;
      6'd41: g = 40'h00_41_7F_41_00;
      6'd42: g = 40'h20_40_41_3F_01;
      6'd43: g = 40'h7F_08_14_22_41;
      6'd44: g = 40'h7F_40_40_40_40;
      6'd45: g = 40'h7F_02_04_02_7F;
      6'd46: g = 40'h7F_04_08_10_7F;
      6'd47: g = 40'h3E_41_41_41_3E;
      6'd48: g = 40'h7F_09_09_09_06;
      6'd49: g = 40'h3E_41_51_21_5E;
      6'd50: g = 40'h7F_09_19_29_46;
      6'd51: g = 40'h46_49_49_49_31;
      6'd52: g = 40'h01_01_7F_01_01;
      6'd53: g = 40'h3F_40_40_40_3F;
      6'd54: g = 40'h1F_20_40_20_1F;
      6'd55: g = 40'h3F_40_38_40_3F;
      6'd56: g = 40'h63_14_08_14_63;
      6'd57: g = 40'h07_08_70_08_07;
      6'd58: g = 40'h61_51_49_45_43;
      default: g = 40'h00_00_00_00_00;
    endcase
    case (c)
      3'd0:    b = g[39:32];
      3'd1:    b = g[31:24];
      3'd2:    b = g[23:16];
      3'd3:    b = g[15:8];
      3'd4:    b = g[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[sv/sgfw_front.sv]
// Command front end: accepts command beats, classifies them and pushes queue entries.
// Depends on sgfw_pkg.
module sgfw_front (
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [6:0]         in_x_pixel,
  input  logic [1:0]         in_page_row,
  input  logic [7:0]         in_char_code,
  input  sgfw_pkg::eng_stat_t eng_stat,
  input  sgfw_pkg::qstat_t   q_stat,
  output logic               push,
  output sgfw_pkg::qentry_t  entry
);
  import sgfw_pkg::*;

  parameter int COLUMNS = DEF_COLUMNS;
  parameter int PAGES   = DEF_PAGES;

  logic known_mode;
  logic code_ok;

  assign busy = q_stat.full | eng_stat.init_busy;

  always_comb begin
    code_ok    = (in_char_code >= FIRST_CODE) && (in_char_code <= LAST_CODE);
    known_mode = 1'b1;
    entry.op   = OP_CLEAR;
    case (in_mode)
      MODE_CLEAR: entry.op = OP_CLEAR;
      MODE_DRAW:  entry.op = OP_DRAW;
      MODE_READ:  entry.op = OP_READ;
      default:    known_mode = 1'b0;
    endcase
    entry.x        = in_x_pixel;
    entry.page     = in_page_row;
    // Unknown codes fall back to the space glyph, which draws nothing.
    entry.glyph    = code_ok ? 6'(in_char_code - FIRST_CODE) : 6'd0;
    entry.in_range = (32'(in_x_pixel) < COLUMNS) && (32'(in_page_row) < PAGES);
  end

  // Mode 3 beats are accepted and dropped here.
  assign push = start & ~busy & known_mode;

endmodule

[sv/sgfw_queue.sv]
// Short command queue between the front end and the drawing engine.
// Depends on sgfw_pkg.
module sgfw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sgfw_pkg::qentry_t entry_in,
  input  logic              pop,
  output sgfw_pkg::qentry_t head,
  output sgfw_pkg::qstat_t  q_stat
);
  import sgfw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qentry_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_stat.avail = (count_r != '0);
  assign head         = slot_r[rptr_r];
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & q_stat.avail;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
      if (do_push) begin
        slot_r[wptr_r] <= entry_in;
      end
    end
  end

endmodule

[sv/sgfw_engine.sv]
// Back end: owns the framebuffer memory and runs clear, scaled draw and readback.
// Depends on sgfw_pkg.
module sgfw_engine #(
  parameter int COLUMNS = sgfw_pkg::DEF_COLUMNS,
  parameter int PAGES   = sgfw_pkg::DEF_PAGES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sgfw_pkg::qentry_t   head,
  input  sgfw_pkg::qstat_t    q_stat,
  output logic                pop,
  output sgfw_pkg::eng_stat_t eng_stat,
  output logic                out_strobe,
  output logic [7:0]          out_read_byte
);
  import sgfw_pkg::*;

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              init_r, init_nxt;
  qentry_t           cmd_r, cmd_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [7:0]        pend_val_r, pend_val_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_r;
  logic              mem_re, mem_we;
  logic [AW-1:0]     raddr, waddr;
  logic [7:0]        wdata;

  logic [2:0]        gcol;
  logic              dx, hi_half;
  logic [7:0]        px;
  logic [2:0]        pg;
  logic              step_ok;
  logic [7:0]        gbyte;
  logic [7:0]        step_val;
  logic [AW-1:0]     draw_addr, read_addr;

  assign eng_stat.init_busy = init_r;
  assign out_strobe         = out_strobe_r;
  assign out_read_byte      = out_byte_r;

  // Step order: glyph column, then destination column, then low/high page.
  always_comb begin
    gcol      = step_r[STEP_W-1:2];
    dx        = step_r[1];
    hi_half   = step_r[0];
    px        = {1'b0, cmd_r.x} + {4'b0, gcol, 1'b0} + {7'b0, dx};
    pg        = {1'b0, cmd_r.page} + {2'b0, hi_half};
    step_ok   = (32'(px) < COLUMNS) && (32'(pg) < PAGES);
    gbyte     = glyph_col(cmd_r.glyph, gcol);
    step_val  = double_nibble(hi_half ? gbyte[7:4] : gbyte[3:0]);
    draw_addr = AW'(32'(pg) * COLUMNS + 32'(px));
    read_addr = AW'(32'(cmd_r.page) * COLUMNS + 32'(cmd_r.x));
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    clr_cnt_nxt    = clr_cnt_r;
    init_nxt       = init_r;
    cmd_nxt        = cmd_r;
    pend_vld_nxt   = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    pend_val_nxt   = pend_val_r;
    out_strobe_nxt = 1'b0;
    out_byte_nxt   = out_byte_r;
    pop            = 1'b0;
    mem_re         = 1'b0;
    raddr          = read_addr;
    // The pending write completes the read-modify-write issued in the previous cycle.
    mem_we         = pend_vld_r;
    waddr          = pend_addr_r;
    wdata          = rdata_r | pend_val_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_cnt_r;
        wdata  = 8'h00;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          init_nxt    = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_stat.avail) begin
          pop     = 1'b1;
          cmd_nxt = head;
          case (head.op)
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            OP_DRAW: begin
              step_nxt  = '0;
              state_nxt = ST_DRAW;
            end
            OP_READ: state_nxt = ST_RD_ISSUE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        mem_re        = step_ok;
        raddr         = draw_addr;
        pend_vld_nxt  = step_ok;
        pend_addr_nxt = draw_addr;
        pend_val_nxt  = step_val;
        if (step_r == STEP_W'(DRAW_STEPS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        mem_re    = 1'b1;
        state_nxt = ST_RD_DONE;
      end
      ST_RD_DONE: begin
        out_strobe_nxt = 1'b1;
        out_byte_nxt   = cmd_r.in_range ? rdata_r : 8'h00;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= '0;
      clr_cnt_r    <= '0;
      init_r       <= 1'b1;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      init_r       <= init_nxt;
      cmd_r        <= cmd_nxt;
      pend_vld_r   <= pend_vld_nxt;
      pend_addr_r  <= pend_addr_nxt;
      pend_val_r   <= pend_val_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_byte_r   <= out_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[sv/scaled_glyph_framebuffer_writer.sv]
// Top level of the scaled glyph framebuffer writer.
// Depends on sgfw_pkg, sgfw_front, sgfw_queue and sgfw_engine.
//
// A command beat is taken when start is high and busy is low. After reset the block
// clears its PAGES*COLUMNS-byte framebuffer one byte per cycle and holds busy high until
// it is done. Commands go through a two-entry queue to the engine, which handles one
// at a time. A scaled draw takes the command, runs 20 read-modify-write steps of one
// byte each (the memory's single read and single write port set this), and then
// finishes the last write. A read shows its byte on out_read_byte with out_strobe high
// for exactly one cycle; the receiver cannot stall it, so it must take the byte in
// that cycle. Mode 3 beats are taken and ignored.
module scaled_glyph_framebuffer_writer #(
  parameter int COLUMNS = sgfw_pkg::DEF_COLUMNS,
  parameter int PAGES   = sgfw_pkg::DEF_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [6:0] in_x_pixel,
  input  logic [1:0] in_page_row,
  input  logic [7:0] in_char_code,
  output logic       out_strobe,
  output logic [7:0] out_read_byte
);
  import sgfw_pkg::*;

  eng_stat_t eng_stat;
  qstat_t    q_stat;
  qentry_t   entry;
  qentry_t   head;
  logic      push;
  logic      pop;

  sgfw_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_x_pixel   (in_x_pixel),
    .in_page_row  (in_page_row),
    .in_char_code (in_char_code),
    .eng_stat     (eng_stat),
    .q_stat       (q_stat),
    .push         (push),
    .entry        (entry)
  );

  sgfw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .entry_in (entry),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  sgfw_engine #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .eng_stat      (eng_stat),
    .out_strobe    (out_strobe),
    .out_read_byte (out_read_byte)
  );

endmodule

[sv/sgfw_checker.sv]
// Port-level checks for the scaled glyph framebuffer writer, bound to its top level.
// Depends on sgfw_pkg and scaled_glyph_framebuffer_writer.
module sgfw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_mode,
  input logic       out_strobe,
  input logic [7:0] out_read_byte
);
  import sgfw_pkg::*;

  // The clearing pass after reset keeps the block from taking beats.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_no_strobe_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // Each read goes from idle through the issue and done states, so two results never come in adjacent cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // The queue only fills when a command beat was taken on the edge before.
  a_busy_rise_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy &&
      (in_mode == MODE_CLEAR || in_mode == MODE_DRAW || in_mode == MODE_READ)))
    else $error("busy rose without a command beat");

  // The framebuffer is cleared before any read, so a result byte is always known.
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_read_byte))
    else $error("result byte unknown");

endmodule

bind scaled_glyph_framebuffer_writer sgfw_checker u_sgfw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .out_strobe    (out_strobe),
  .out_read_byte (out_read_byte)
);
